/* design/rtt_timeout_estimator_defines.svh */
// Assertion macros shared by the RTT timeout estimator modules.
`ifndef RTT_TIMEOUT_ESTIMATOR_DEFINES_SVH
`define RTT_TIMEOUT_ESTIMATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rte check failed: same-cycle rule");

// Consequent must hold in the cycle after the antecedent.
`define RTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rte check failed: next-cycle rule");

`endif

/* design/rte_pkg.sv */
// Shared types and constants for the RTT timeout estimator.
package rte_pkg;

  typedef struct packed {
    logic [31:0] start_sec;
    logic [19:0] start_usec;
    logic [31:0] end_sec;
    logic [19:0] end_usec;
  } rte_in_t;

  typedef struct packed {
    logic [31:0] timeout_ms;
    logic [31:0] smoothed_ms;
    logic [31:0] deviation_ms;
    logic [31:0] sample_ms;
    logic        seeded;
  } rte_out_t;

  // Filter result handed to the output stage.
  typedef struct packed {
    logic [31:0] sample_ms;
    logic [31:0] smoothed_ms;
    logic [31:0] deviation_ms;
    logic        seeded;
  } rte_est_t;

  localparam logic [31:0]        MAX32          = 32'hFFFF_FFFF;
  localparam logic signed [43:0] MS_PER_SEC     = 44'sd1000;
  // floor(x / 1000) = (x * MS_RECIP) >> 30 for x below 2^21
  localparam logic [20:0]        MS_RECIP       = 21'd1073742;
  localparam logic [20:0]        USEC_ROUND     = 21'd999;
  localparam logic [4:0]         SMOOTH_SHIFT_RST = 5'd3;
  localparam logic [4:0]         DEV_SHIFT_RST    = 5'd2;

  localparam logic REG_SMOOTH_SHIFT = 1'b0;
  localparam logic REG_DEV_SHIFT    = 1'b1;

endpackage

/* design/rte_sample_pipe.sv */
// Timestamp difference to millisecond RTT sample, four pipeline stages.
`include "rtt_timeout_estimator_defines.svh"

module rte_sample_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rte_pkg::rte_in_t in_data,
  output logic            sample_valid,
  input  logic            sample_ready,
  output logic [31:0]     sample_ms
);
  import rte_pkg::*;

  logic                v1, v2, v3, v4;
  logic                rdy1, rdy2, rdy3, rdy4;
  rte_in_t             d1;
  logic signed [32:0]  dsec2;
  logic                neg2, neg3;
  logic [20:0]         t2;
  logic signed [43:0]  msec3;
  logic [10:0]         qa3;
  logic [31:0]         sample4;

  logic signed [32:0]  dsec_c;
  logic signed [20:0]  dusec_c;
  logic [20:0]         mag_c;
  logic [20:0]         t_c;
  logic signed [43:0]  dsec_ext;
  logic signed [43:0]  msec_c;
  logic [41:0]         prod_c;
  logic signed [43:0]  qs_c;
  logic signed [43:0]  ms_c;
  logic [31:0]         sample_c;

  assign rdy4 = !v4 || sample_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;
  assign sample_valid = v4;
  assign sample_ms = sample4;

  // Stage 1: split into seconds and signed microsecond differences.
  always_comb begin
    dsec_c  = $signed({1'b0, d1.end_sec}) - $signed({1'b0, d1.start_sec});
    dusec_c = $signed({1'b0, d1.end_usec}) - $signed({1'b0, d1.start_usec});
    mag_c   = dusec_c[20] ? 21'(-dusec_c) : 21'(dusec_c);
    // round magnitude up for negatives so the quotient floors
    t_c     = dusec_c[20] ? mag_c + USEC_ROUND : mag_c;
  end

  // Stage 2: seconds to ms, microseconds to ms by reciprocal multiply.
  always_comb begin
    dsec_ext = 44'(dsec2);
    msec_c   = dsec_ext * MS_PER_SEC;
    prod_c   = 42'(t2) * 42'(MS_RECIP);
  end

  // Stage 3: combine, clamp negatives, saturate at 32 bits.
  always_comb begin
    qs_c = $signed({33'b0, qa3});
    ms_c = neg3 ? msec3 - qs_c : msec3 + qs_c;
    if (ms_c[43]) begin
      sample_c = '0;
    end else if (|ms_c[42:32]) begin
      sample_c = MAX32;
    end else begin
      sample_c = ms_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      d1 <= in_data;
    end
    if (rdy2) begin
      dsec2 <= dsec_c;
      neg2  <= dusec_c[20];
      t2    <= t_c;
    end
    if (rdy3) begin
      msec3 <= msec_c;
      neg3  <= neg2;
      qa3   <= prod_c[40:30];
    end
    if (rdy4) begin
      sample4 <= sample_c;
    end
  end

  // Quotient of the rounded microsecond magnitude (at most 1049574) by 1000 never exceeds 1049.
  `RTE_ASSERT_NOW(a_quot_range, clk, rst, v3, qa3 <= 11'd1049)

endmodule

/* design/rte_filter.sv */
// Smoothed RTT and deviation state with their moving-average update.
`include "rtt_timeout_estimator_defines.svh"

module rte_filter (
  input  logic             clk,
  input  logic             rst,
  input  logic [4:0]       smooth_shift,
  input  logic [4:0]       deviation_shift,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  logic [31:0]      sample_ms,
  output logic             est_valid,
  input  logic             est_ready,
  output rte_pkg::rte_est_t est
);
  import rte_pkg::*;

  logic [31:0] smoothed_rtt, smoothed_rtt_next;
  logic [31:0] rtt_deviation, rtt_deviation_next;
  logic        v5;
  rte_est_t    est5;
  logic        adv;
  logic        seed_c;
  logic [31:0] diff_c;
  logic [32:0] est_sum;
  logic [32:0] dev_sum;

  assign sample_ready = !v5 || est_ready;
  assign adv = sample_valid && sample_ready;
  assign est_valid = v5;
  assign est = est5;

  always_comb begin
    seed_c  = (smoothed_rtt == '0);
    diff_c  = (sample_ms > smoothed_rtt) ? sample_ms - smoothed_rtt
                                         : smoothed_rtt - sample_ms;
    est_sum = {1'b0, smoothed_rtt - (smoothed_rtt >> smooth_shift)}
            + {1'b0, sample_ms >> smooth_shift};
    dev_sum = {1'b0, rtt_deviation - (rtt_deviation >> deviation_shift)}
            + {1'b0, diff_c >> deviation_shift};
    if (seed_c) begin
      smoothed_rtt_next  = sample_ms;
      rtt_deviation_next = '0;
    end else begin
      smoothed_rtt_next  = est_sum[32] ? MAX32 : est_sum[31:0];
      rtt_deviation_next = dev_sum[32] ? MAX32 : dev_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_rtt  <= '0;
      rtt_deviation <= '0;
      v5            <= 1'b0;
    end else begin
      if (sample_ready) v5 <= sample_valid;
      if (adv) begin
        smoothed_rtt  <= smoothed_rtt_next;
        rtt_deviation <= rtt_deviation_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      est5.sample_ms    <= sample_ms;
      est5.smoothed_ms  <= smoothed_rtt_next;
      est5.deviation_ms <= rtt_deviation_next;
      est5.seeded       <= seed_c;
    end
  end

  // State moves only on a transfer into this stage.
  `RTE_ASSERT_NEXT(a_state_hold, clk, rst, !adv,
    $stable(smoothed_rtt) && $stable(rtt_deviation))
  // A seeding result carries the sample as the average and no deviation.
  `RTE_ASSERT_NOW(a_seed_result, clk, rst, v5 && est5.seeded,
    est5.deviation_ms == '0 && est5.smoothed_ms == est5.sample_ms)

endmodule

/* design/rte_output.sv */
// Timeout computation and result register.
`include "rtt_timeout_estimator_defines.svh"

module rte_output (
  input  logic              clk,
  input  logic              rst,
  input  logic              est_valid,
  output logic              est_ready,
  input  rte_pkg::rte_est_t est,
  output logic              out_valid,
  input  logic              out_ready,
  output rte_pkg::rte_out_t out_data
);
  import rte_pkg::*;

  logic        v6;
  rte_out_t    res6;
  logic [34:0] sum_c;
  logic [31:0] timeout_c;

  assign est_ready = !v6 || out_ready;
  assign out_valid = v6;
  assign out_data  = res6;

  always_comb begin
    if (est.seeded) begin
      sum_c = {2'b0, est.sample_ms, 1'b0};
    end else begin
      sum_c = {3'b0, est.smoothed_ms} + {1'b0, est.deviation_ms, 2'b0};
    end
    timeout_c = (|sum_c[34:32]) ? MAX32 : sum_c[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (est_ready) begin
      v6 <= est_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (est_ready && est_valid) begin
      res6.timeout_ms   <= timeout_c;
      res6.smoothed_ms  <= est.smoothed_ms;
      res6.deviation_ms <= est.deviation_ms;
      res6.sample_ms    <= est.sample_ms;
      res6.seeded       <= est.seeded;
    end
  end

  // Timeout never falls below the smoothed RTT it is built on.
  `RTE_ASSERT_NOW(a_timeout_floor, clk, rst, v6, res6.timeout_ms >= res6.smoothed_ms)

endmodule

/* design/rtt_timeout_estimator.sv */
// Result path: six registers (4 sample stages, filter stage, output register); the
// input transfer loads the first.
// Throughput: one item per cycle while out_ready is held high; the only feedback
// loop is the smoothed RTT and deviation update in the filter stage.
// Reset: synchronous; clears pipeline valids and the estimator state and
// loads smooth_shift = 3, deviation_shift = 2.
module rtt_timeout_estimator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rte_pkg::rte_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rte_pkg::rte_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [4:0]        cfg_data
);
  import rte_pkg::*;

  logic [4:0]  smooth_shift;
  logic [4:0]  deviation_shift;
  logic        sample_valid, sample_ready;
  logic [31:0] sample_ms;
  logic        est_valid, est_ready;
  rte_est_t    est;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_shift    <= SMOOTH_SHIFT_RST;
      deviation_shift <= DEV_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTH_SHIFT: smooth_shift    <= cfg_data;
        REG_DEV_SHIFT:    deviation_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  rte_sample_pipe u_sample (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_ms    (sample_ms)
  );

  rte_filter u_filter (
    .clk             (clk),
    .rst             (rst),
    .smooth_shift    (smooth_shift),
    .deviation_shift (deviation_shift),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .sample_ms       (sample_ms),
    .est_valid       (est_valid),
    .est_ready       (est_ready),
    .est             (est)
  );

  rte_output u_output (
    .clk       (clk),
    .rst       (rst),
    .est_valid (est_valid),
    .est_ready (est_ready),
    .est       (est),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
